FILE: src/banked_core_alu_branch_exec_core_defines.svh
// Assertion macros used by the checker file of the execution core.
`ifndef BANKED_CORE_ALU_BRANCH_EXEC_CORE_DEFINES_SVH
`define BANKED_CORE_ALU_BRANCH_EXEC_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define BCE_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define BCE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);

`endif

FILE: src/bce_pkg.sv
// Types, codes and datapath helper functions of the banked execution core.
package bce_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] instruction;
    } bce_in_t;

    typedef struct packed {
        logic [2:0]  result_status;
        logic        flushed;
        logic [31:0] next_pc;
        logic [31:0] status_word;
        logic        reg_written;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
    } bce_out_t;

    typedef struct packed {
        logic        c;
        logic [31:0] v;
    } shres_t;

    typedef struct packed {
        logic        c;
        logic        o;
        logic [31:0] r;
    } addres_t;

    // Event kinds
    localparam logic [2:0] KIND_WIDE    = 3'd0;
    localparam logic [2:0] KIND_COMPACT = 3'd1;
    localparam logic [2:0] KIND_IRQ     = 3'd2;
    localparam logic [2:0] KIND_FIQ     = 3'd3;
    localparam logic [2:0] KIND_RESET   = 3'd4;
    localparam logic [2:0] KIND_UND     = 3'd5;
    localparam logic [2:0] KIND_PABT    = 3'd6;
    localparam logic [2:0] KIND_DABT    = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_EXEC   = 3'd0;
    localparam logic [2:0] ST_COND   = 3'd1;
    localparam logic [2:0] ST_UNSUP  = 3'd2;
    localparam logic [2:0] ST_WRONG  = 3'd3;
    localparam logic [2:0] ST_MASKED = 3'd4;

    // Modes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;

    // Exception vectors
    localparam logic [31:0] VEC_UND  = 32'h04;
    localparam logic [31:0] VEC_SWI  = 32'h08;
    localparam logic [31:0] VEC_PABT = 32'h0C;
    localparam logic [31:0] VEC_DABT = 32'h10;
    localparam logic [31:0] VEC_IRQ  = 32'h18;
    localparam logic [31:0] VEC_FIQ  = 32'h1C;

    // Register file geometry: 8 low, 5 shared high, 5 fast high, 6 banked pairs
    localparam int RF_DEPTH = 30;
    localparam int RF_AW    = 5;
    localparam int SV_DEPTH = 5;

    // Wide data processing opcodes
    localparam logic [3:0] DP_AND = 4'd0;
    localparam logic [3:0] DP_EOR = 4'd1;
    localparam logic [3:0] DP_SUB = 4'd2;
    localparam logic [3:0] DP_RSB = 4'd3;
    localparam logic [3:0] DP_ADD = 4'd4;
    localparam logic [3:0] DP_ADC = 4'd5;
    localparam logic [3:0] DP_SBC = 4'd6;
    localparam logic [3:0] DP_RSC = 4'd7;
    localparam logic [3:0] DP_TST = 4'd8;
    localparam logic [3:0] DP_TEQ = 4'd9;
    localparam logic [3:0] DP_CMP = 4'd10;
    localparam logic [3:0] DP_CMN = 4'd11;
    localparam logic [3:0] DP_ORR = 4'd12;
    localparam logic [3:0] DP_MOV = 4'd13;
    localparam logic [3:0] DP_BIC = 4'd14;
    localparam logic [3:0] DP_MVN = 4'd15;

    // Compact low-register ALU opcodes
    localparam logic [3:0] TA_AND = 4'd0;
    localparam logic [3:0] TA_EOR = 4'd1;
    localparam logic [3:0] TA_LSL = 4'd2;
    localparam logic [3:0] TA_LSR = 4'd3;
    localparam logic [3:0] TA_ASR = 4'd4;
    localparam logic [3:0] TA_ADC = 4'd5;
    localparam logic [3:0] TA_SBC = 4'd6;
    localparam logic [3:0] TA_ROR = 4'd7;
    localparam logic [3:0] TA_TST = 4'd8;
    localparam logic [3:0] TA_NEG = 4'd9;
    localparam logic [3:0] TA_CMP = 4'd10;
    localparam logic [3:0] TA_CMN = 4'd11;
    localparam logic [3:0] TA_ORR = 4'd12;
    localparam logic [3:0] TA_MUL = 4'd13;
    localparam logic [3:0] TA_BIC = 4'd14;
    localparam logic [3:0] TA_MVN = 4'd15;

    // Compact high-register opcodes
    localparam logic [1:0] HI_ADD = 2'd0;
    localparam logic [1:0] HI_CMP = 2'd1;
    localparam logic [1:0] HI_MOV = 2'd2;
    localparam logic [1:0] HI_BX  = 2'd3;

    // Compact immediate opcodes
    localparam logic [1:0] IM_MOV = 2'd0;
    localparam logic [1:0] IM_CMP = 2'd1;
    localparam logic [1:0] IM_ADD = 2'd2;
    localparam logic [1:0] IM_SUB = 2'd3;

    // Shift types
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    // Instruction class patterns
    localparam logic [31:0] BX_MASK   = 32'h0FFF_FFF0;
    localparam logic [31:0] BX_MATCH  = 32'h012F_FF10;
    localparam logic [31:0] SWI_MASK  = 32'h0F00_0000;
    localparam logic [31:0] B_MASK    = 32'h0E00_0000;
    localparam logic [31:0] B_MATCH   = 32'h0A00_0000;
    localparam logic [31:0] MUL_MASK  = 32'h0E00_0090;
    localparam logic [31:0] MUL_MATCH = 32'h0000_0090;

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] r);
        logic [63:0] t;
        t = {v, v} >> r;
        return t[31:0];
    endfunction

    function automatic shres_t shift_imm(input logic [1:0] ty, input logic [31:0] v,
                                         input logic [4:0] amt, input logic cin);
        shres_t      s;
        logic [32:0] t;
        logic [31:0] r;
        t = '0;
        r = '0;
        case (ty)
            SH_LSL: begin
                t = {1'b0, v} << amt;
                s.c = (amt == 5'd0) ? cin : t[32];
                s.v = t[31:0];
            end
            SH_LSR: begin
                t = {v, 1'b0} >> amt;
                s.c = (amt == 5'd0) ? v[31] : t[0];
                s.v = (amt == 5'd0) ? 32'd0 : t[32:1];
            end
            SH_ASR: begin
                t = 33'($signed({v, 1'b0}) >>> amt);
                s.c = (amt == 5'd0) ? v[31] : t[0];
                s.v = (amt == 5'd0) ? {32{v[31]}} : t[32:1];
            end
            default: begin
                r = rotr32(v, amt);
                s.c = (amt == 5'd0) ? v[0] : r[31];
                s.v = (amt == 5'd0) ? {cin, v[31:1]} : r;
            end
        endcase
        return s;
    endfunction

    function automatic shres_t shift_reg(input logic [1:0] ty, input logic [31:0] v,
                                         input logic [7:0] amt, input logic cin);
        shres_t      s;
        logic [32:0] t;
        logic        big;
        logic        exact;
        big   = amt >= 8'd32;
        exact = amt == 8'd32;
        t     = '0;
        s.c   = cin;
        s.v   = v;
        if (amt != 8'd0) begin
            case (ty)
                SH_LSL: begin
                    t = {1'b0, v} << amt[4:0];
                    s.c = big ? (exact & v[0]) : t[32];
                    s.v = big ? 32'd0 : t[31:0];
                end
                SH_LSR: begin
                    t = {v, 1'b0} >> amt[4:0];
                    s.c = big ? (exact & v[31]) : t[0];
                    s.v = big ? 32'd0 : t[32:1];
                end
                SH_ASR: begin
                    t = 33'($signed({v, 1'b0}) >>> amt[4:0]);
                    s.c = big ? v[31] : t[0];
                    s.v = big ? {32{v[31]}} : t[32:1];
                end
                default: begin
                    s.v = rotr32(v, amt[4:0]);
                    s.c = s.v[31];
                end
            endcase
        end
        return s;
    endfunction

    function automatic addres_t add_c(input logic [31:0] a, input logic [31:0] b,
                                      input logic cin);
        addres_t     res;
        logic [32:0] s;
        s     = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        res.r = s[31:0];
        res.c = s[32];
        res.o = (a[31] ^ s[31]) & (b[31] ^ s[31]);
        return res;
    endfunction

    // nzcv packed as {N, Z, C, V}
    function automatic logic cond_ok(input logic [3:0] cnd, input logic [3:0] nzcv);
        logic n, z, c, v, ok;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (cnd)
            4'd0:    ok = z;
            4'd1:    ok = !z;
            4'd2:    ok = c;
            4'd3:    ok = !c;
            4'd4:    ok = n;
            4'd5:    ok = !n;
            4'd6:    ok = v;
            4'd7:    ok = !v;
            4'd8:    ok = c && !z;
            4'd9:    ok = !c || z;
            4'd10:   ok = n == v;
            4'd11:   ok = n != v;
            4'd12:   ok = !z && (n == v);
            4'd13:   ok = z || (n != v);
            COND_AL: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Bank 0 is user/system; 1..5 are fiq, svc, abt, irq, und
    function automatic logic [2:0] bank_of(input logic [4:0] mode);
        logic [2:0] b;
        unique case (mode)
            MODE_FIQ: b = 3'd1;
            MODE_SVC: b = 3'd2;
            MODE_ABT: b = 3'd3;
            MODE_IRQ: b = 3'd4;
            MODE_UND: b = 3'd5;
            default:  b = 3'd0;
        endcase
        return b;
    endfunction

    function automatic logic mode_valid(input logic [4:0] mode);
        return (mode == MODE_USR) || (mode == MODE_FIQ) || (mode == MODE_IRQ) ||
               (mode == MODE_SVC) || (mode == MODE_ABT) || (mode == MODE_UND) ||
               (mode == MODE_SYS);
    endfunction

    // Physical register file slot of an architectural register in a mode
    function automatic logic [RF_AW-1:0] phys_of(input logic [3:0] idx,
                                                 input logic [4:0] mode);
        logic [2:0] bk;
        bk = bank_of(mode);
        if (!idx[3]) begin
            return {2'b00, idx[2:0]};
        end else if (idx < 4'd13) begin
            return (mode == MODE_FIQ) ? (RF_AW'(idx) + RF_AW'(5)) : RF_AW'(idx);
        end else begin
            return RF_AW'(18) + {1'b0, bk, 1'b0} + {4'b0000, ~idx[0]};
        end
    endfunction

endpackage

FILE: src/banked_core_alu_branch_exec_core.sv
// Top level of the banked execution core: decode, register file and execute.
//
// One event enters per item (wide or compact instruction, irq, fiq, reset,
// undefined or abort exception) and leaves one result item with status,
// flush flag, new PC, status word and the general register write, if any.
// The 30 physical registers (low, shared high, fast high and six banked
// SP/LR pairs) live in a synchronous memory with two read ports and one write
// port; a valid bit per entry makes a never-written or reset-cleared entry
// read as zero, so a reset event takes effect at once without a clearing
// pass. Items flow through a read stage (register addresses issued) and an
// execute stage (operands back, ALU, shifter, flags, write back), and a
// result register decouples the output so the next item is taken while a
// result waits. Throughput is one item per cycle while the output is not
// stalled. An item that follows an item which flushed (branch, exception
// entry, reset) waits in the read stage, since its register reads are
// re-issued under the possibly new mode. A wide item with bits 27..25 clear
// and bit 4 set (the register-specified shift, and likewise BX and the
// multiply and halfword patterns) takes a second read phase, as a shift
// amount register is read through the same port first.
module banked_core_alu_branch_exec_core
    import bce_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bce_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bce_out_t m_data
);

    // ------------------------------------------------------------------
    // Architectural state outside the register file
    // ------------------------------------------------------------------
    logic [31:0] pc_reg;
    logic [31:0] cpsr_reg;
    logic [31:0] saved_reg [SV_DEPTH];

    // Register file memory, valid bits and read pipeline
    logic [31:0]         rf_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] rf_valid_reg;
    logic [31:0]         ra_data_reg;
    logic [31:0]         rb_data_reg;
    logic [RF_AW-1:0]    ra_addr_reg;
    logic [RF_AW-1:0]    rb_addr_reg;
    logic                va_reg;
    logic                vb_reg;

    // Last write, kept for forwarding into a read issued at the same edge
    logic             fw_en_reg;
    logic [RF_AW-1:0] fw_addr_reg;
    logic [31:0]      fw_data_reg;

    // Read stage
    logic    s1_valid_reg;
    logic    s1_ph_reg;
    bce_in_t s1_data_reg;

    // Execute stage
    logic        s2_valid_reg;
    bce_in_t     s2_data_reg;
    logic [31:0] s2_rs_reg;

    // Result register
    logic     m_valid_reg;
    bce_out_t m_data_reg;

    // Handshake and stage control
    logic             out_free;
    logic             commit;
    logic             s1_needs2;
    logic             s1_adv;
    logic             s1_ph_go;
    logic [RF_AW-1:0] rd_a;
    logic [RF_AW-1:0] rd_b;
    logic [31:0]      opa;
    logic [31:0]      opb;

    // Execute results
    logic [2:0]       ex_st;
    logic             ex_fl;
    logic [31:0]      ex_pc;
    logic [31:0]      ex_cpsr;
    logic             ex_wr;
    logic [3:0]       ex_wr_idx;
    logic [31:0]      ex_wr_val;
    logic [RF_AW-1:0] ex_wr_phys;
    logic             ex_sv;
    logic [2:0]       ex_sv_idx;
    logic             ex_rst;

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = s2_valid_reg && out_free;

    // Register-shifted wide data processing reads its shift register first
    assign s1_needs2 = (s1_data_reg.kind == KIND_WIDE) &&
                       (s1_data_reg.instruction[27:26] == 2'b00) &&
                       !s1_data_reg.instruction[25] && s1_data_reg.instruction[4];

    // Advance only when execute frees up and no flush invalidates the reads
    assign s1_adv = s1_valid_reg && (!s1_needs2 || s1_ph_reg) &&
                    (!s2_valid_reg || commit) && !(commit && ex_fl);

    // Shift-register read done once execute will be empty next cycle
    assign s1_ph_go = s1_valid_reg && s1_needs2 && !s1_ph_reg &&
                      (!s2_valid_reg || (commit && !ex_fl));

    assign s_ready = !s1_valid_reg || s1_adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Read address decode (under the mode held now; re-issued after a flush)
    // ------------------------------------------------------------------
    always_comb begin
        logic [31:0] ins;
        logic [3:0]  ia;
        logic [3:0]  ib;
        ins = s1_data_reg.instruction;
        ia  = 4'd0;
        ib  = 4'd0;
        if (s1_data_reg.kind == KIND_WIDE) begin
            ia = (s1_needs2 && !s1_ph_reg) ? ins[11:8] : ins[19:16];
            ib = ins[3:0];
        end else begin
            if ((ins[15:0] & 16'hF800) == 16'hF800) begin
                ia = 4'd14;
            end else if ((ins[15:0] & 16'hFC00) == 16'h4400) begin
                ia = {ins[7], ins[2:0]};
                ib = {ins[6], ins[5:3]};
            end else if ((ins[15:0] & 16'hFC00) == 16'h4000) begin
                ia = {1'b0, ins[2:0]};
                ib = {1'b0, ins[5:3]};
            end else if ((ins[15:0] & 16'hE000) == 16'h2000) begin
                ia = {1'b0, ins[10:8]};
            end else begin
                // add/sub register and shift by immediate share these fields
                ia = {1'b0, ins[5:3]};
                ib = {1'b0, ins[8:6]};
            end
        end
        rd_a = phys_of(ia, cpsr_reg[4:0]);
        rd_b = phys_of(ib, cpsr_reg[4:0]);
    end

    // Forward the write of the same edge; an unwritten entry reads as zero
    assign opa = (fw_en_reg && (fw_addr_reg == ra_addr_reg)) ? fw_data_reg :
                 (va_reg ? ra_data_reg : 32'd0);
    assign opb = (fw_en_reg && (fw_addr_reg == rb_addr_reg)) ? fw_data_reg :
                 (vb_reg ? rb_data_reg : 32'd0);

    // ------------------------------------------------------------------
    // Execute
    // ------------------------------------------------------------------
    always_comb begin
        logic [31:0] ins;
        logic [31:0] pc;
        logic        cf;
        logic        tb;
        logic [2:0]  bk;
        logic [31:0] sv_cur;
        logic        exc_go;
        logic        exc_swi;
        logic [4:0]  exc_mode;
        logic [31:0] exc_vec;
        logic [31:0] exc_ret;
        logic [31:0] step;
        logic [4:0]  wr_mode;
        logic [3:0]  op4;
        logic [1:0]  op2b;
        logic        sflag;
        logic        test;
        logic [3:0]  dst;
        logic        rsh;
        logic [31:0] rn_v;
        logic [31:0] rm_v;
        logic [31:0] op2;
        logic        c2;
        logic [31:0] res;
        logic        arith;
        addres_t     ar;
        shres_t      sh;
        logic [31:0] off;
        logic [31:0] tgt;
        logic [31:0] lv;
        logic [31:0] rv;
        logic [3:0]  hsrc;
        logic [3:0]  hdst;
        logic [4:0]  rot;

        ins      = s2_data_reg.instruction;
        pc       = pc_reg;
        cf       = cpsr_reg[29];
        tb       = cpsr_reg[5];
        bk       = bank_of(cpsr_reg[4:0]);
        sv_cur   = (bk == 3'd0) ? 32'd0 : saved_reg[bk - 3'd1];
        exc_go   = 1'b0;
        exc_swi  = 1'b0;
        exc_mode = MODE_SVC;
        exc_vec  = VEC_SWI;
        exc_ret  = pc;
        step     = tb ? 32'd2 : 32'd4;
        wr_mode  = cpsr_reg[4:0];
        op4      = 4'd0;
        op2b     = 2'd0;
        sflag    = 1'b0;
        test     = 1'b0;
        dst      = 4'd0;
        rsh      = 1'b0;
        rn_v     = 32'd0;
        rm_v     = 32'd0;
        op2      = 32'd0;
        c2       = cf;
        res      = 32'd0;
        arith    = 1'b0;
        ar       = '0;
        sh       = '0;
        off      = 32'd0;
        tgt      = 32'd0;
        lv       = 32'd0;
        rv       = 32'd0;
        hsrc     = 4'd0;
        hdst     = 4'd0;
        rot      = 5'd0;

        ex_st     = ST_EXEC;
        ex_fl     = 1'b0;
        ex_pc     = pc;
        ex_cpsr   = cpsr_reg;
        ex_wr     = 1'b0;
        ex_wr_idx = 4'd0;
        ex_wr_val = 32'd0;
        ex_sv     = 1'b0;
        ex_sv_idx = 3'd0;
        ex_rst    = 1'b0;

        case (s2_data_reg.kind)
            KIND_WIDE: begin
                rsh  = !ins[25] && ins[4];
                rn_v = (ins[19:16] == 4'd15) ? (pc + (rsh ? 32'd12 : 32'd8)) : opa;
                rm_v = (ins[3:0] == 4'd15) ? (pc + (rsh ? 32'd12 : 32'd8)) : opb;
                if (tb) begin
                    ex_st = ST_WRONG;
                end else if (ins[31:28] == COND_NV) begin
                    ex_st = ST_UNSUP;
                end else if (!cond_ok(ins[31:28], cpsr_reg[31:28])) begin
                    ex_st = ST_COND;
                    ex_pc = pc + 32'd4;
                end else if ((ins & BX_MASK) == BX_MATCH) begin
                    tgt = (ins[3:0] == 4'd15) ? (pc + 32'd8) : opb;
                    ex_cpsr[5] = tgt[0];
                    ex_pc = tgt[0] ? (tgt & ~32'd1) : (tgt & ~32'd3);
                    ex_fl = 1'b1;
                end else if ((ins & SWI_MASK) == SWI_MASK) begin
                    exc_go  = 1'b1;
                    exc_swi = 1'b1;
                end else if ((ins & B_MASK) == B_MATCH) begin
                    off = {{6{ins[23]}}, ins[23:0], 2'b00};
                    if (ins[24]) begin
                        ex_wr     = 1'b1;
                        ex_wr_idx = 4'd14;
                        ex_wr_val = pc + 32'd4;
                    end
                    ex_pc = (pc + 32'd8 + off) & ~32'd3;
                    ex_fl = 1'b1;
                end else if ((ins[27:26] != 2'b00) || ((ins & MUL_MASK) == MUL_MATCH)) begin
                    ex_st = ST_UNSUP;
                end else begin
                    op4   = ins[24:21];
                    sflag = ins[20];
                    test  = op4[3:2] == 2'b10;
                    dst   = ins[15:12];
                    if (ins[25]) begin
                        rot = {ins[11:8], 1'b0};
                        op2 = rotr32({24'd0, ins[7:0]}, rot);
                        c2  = (rot == 5'd0) ? cf : op2[31];
                    end else if (rsh) begin
                        sh  = shift_reg(ins[6:5], rm_v, s2_rs_reg[7:0], cf);
                        op2 = sh.v;
                        c2  = sh.c;
                    end else begin
                        sh  = shift_imm(ins[6:5], rm_v, ins[11:7], cf);
                        op2 = sh.v;
                        c2  = sh.c;
                    end
                    case (op4) inside
                        DP_AND, DP_TST: res = rn_v & op2;
                        DP_EOR, DP_TEQ: res = rn_v ^ op2;
                        DP_SUB, DP_CMP: begin ar = add_c(rn_v, ~op2, 1'b1); arith = 1'b1; end
                        DP_RSB:         begin ar = add_c(op2, ~rn_v, 1'b1); arith = 1'b1; end
                        DP_ADD, DP_CMN: begin ar = add_c(rn_v, op2, 1'b0); arith = 1'b1; end
                        DP_ADC:         begin ar = add_c(rn_v, op2, cf); arith = 1'b1; end
                        DP_SBC:         begin ar = add_c(rn_v, ~op2, cf); arith = 1'b1; end
                        DP_RSC:         begin ar = add_c(op2, ~rn_v, cf); arith = 1'b1; end
                        DP_ORR:         res = rn_v | op2;
                        DP_MOV:         res = op2;
                        DP_BIC:         res = rn_v & ~op2;
                        default:        res = ~op2;
                    endcase
                    if (arith) begin
                        res = ar.r;
                    end
                    if (test && !sflag) begin
                        ex_st = ST_UNSUP;
                    end else if (!test && (dst == 4'd15) && sflag && (bk == 3'd0)) begin
                        ex_st = ST_UNSUP;
                    end else if (rsh && (ins[11:8] == 4'd15)) begin
                        // PC as the shift amount register is not supported
                        ex_st = ST_UNSUP;
                    end else if (!test && (dst == 4'd15)) begin
                        // Status return: a saved status without a valid mode is ignored
                        if (sflag && mode_valid(sv_cur[4:0])) begin
                            ex_cpsr = sv_cur;
                        end
                        ex_pc = ex_cpsr[5] ? (res & ~32'd1) : (res & ~32'd3);
                        ex_fl = 1'b1;
                    end else begin
                        if (!test) begin
                            ex_wr     = 1'b1;
                            ex_wr_idx = dst;
                            ex_wr_val = res;
                        end
                        if (sflag) begin
                            ex_cpsr[31] = res[31];
                            ex_cpsr[30] = res == 32'd0;
                            ex_cpsr[29] = arith ? ar.c : c2;
                            if (arith) begin
                                ex_cpsr[28] = ar.o;
                            end
                        end
                        ex_pc = pc + 32'd4;
                    end
                end
            end

            KIND_COMPACT: begin
                if (!tb) begin
                    ex_st = ST_WRONG;
                end else if ((ins[15:0] & 16'hF800) == 16'hF000) begin
                    off       = {{9{ins[10]}}, ins[10:0], 12'd0};
                    ex_wr     = 1'b1;
                    ex_wr_idx = 4'd14;
                    ex_wr_val = pc + 32'd4 + off;
                    ex_pc     = pc + 32'd2;
                end else if ((ins[15:0] & 16'hF800) == 16'hF800) begin
                    tgt       = opa + {20'd0, ins[10:0], 1'b0};
                    ex_wr     = 1'b1;
                    ex_wr_idx = 4'd14;
                    ex_wr_val = (pc + 32'd2) | 32'd1;
                    ex_pc     = tgt & ~32'd1;
                    ex_fl     = 1'b1;
                end else if ((ins[15:0] & 16'hF800) == 16'hE000) begin
                    off   = {{20{ins[10]}}, ins[10:0], 1'b0};
                    ex_pc = (pc + 32'd4 + off) & ~32'd1;
                    ex_fl = 1'b1;
                end else if ((ins[15:0] & 16'hF000) == 16'hD000) begin
                    off = {{23{ins[7]}}, ins[7:0], 1'b0};
                    if (ins[11:8] == COND_NV) begin
                        exc_go  = 1'b1;
                        exc_swi = 1'b1;
                    end else if (ins[11:8] == COND_AL) begin
                        ex_st = ST_UNSUP;
                    end else if (!cond_ok(ins[11:8], cpsr_reg[31:28])) begin
                        ex_st = ST_COND;
                        ex_pc = pc + 32'd2;
                    end else begin
                        ex_pc = (pc + 32'd4 + off) & ~32'd1;
                        ex_fl = 1'b1;
                    end
                end else if ((ins[15:0] & 16'hFC00) == 16'h4400) begin
                    op2b = ins[9:8];
                    hdst = {ins[7], ins[2:0]};
                    hsrc = {ins[6], ins[5:3]};
                    lv   = (hdst == 4'd15) ? ((pc + 32'd4) & ~32'd1) : opa;
                    rv   = (hsrc == 4'd15) ? ((pc + 32'd4) & ~32'd1) : opb;
                    if ((op2b != HI_BX) && !ins[7] && !ins[6]) begin
                        ex_st = ST_UNSUP;
                    end else if (op2b == HI_BX) begin
                        if (ins[7] || (ins[2:0] != 3'd0)) begin
                            ex_st = ST_UNSUP;
                        end else begin
                            ex_cpsr[5] = rv[0];
                            ex_pc = rv[0] ? (rv & ~32'd1) : (rv & ~32'd3);
                            ex_fl = 1'b1;
                        end
                    end else if (op2b == HI_CMP) begin
                        ar = add_c(lv, ~rv, 1'b1);
                        ex_cpsr[31:28] = {ar.r[31], ar.r == 32'd0, ar.c, ar.o};
                        ex_pc = pc + 32'd2;
                    end else begin
                        res = (op2b == HI_ADD) ? (lv + rv) : rv;
                        if (hdst == 4'd15) begin
                            ex_pc = res & ~32'd1;
                            ex_fl = 1'b1;
                        end else begin
                            ex_wr     = 1'b1;
                            ex_wr_idx = hdst;
                            ex_wr_val = res;
                            ex_pc     = pc + 32'd2;
                        end
                    end
                end else if ((ins[15:0] & 16'hFC00) == 16'h4000) begin
                    op4 = ins[9:6];
                    lv  = opa;
                    rv  = opb;
                    ex_wr     = 1'b1;
                    ex_wr_idx = {1'b0, ins[2:0]};
                    case (op4) inside
                        TA_AND: res = lv & rv;
                        TA_EOR: res = lv ^ rv;
                        TA_LSL, TA_LSR, TA_ASR, TA_ROR: begin
                            sh  = shift_reg((op4 == TA_ROR) ? SH_ROR : 2'(op4 - TA_LSL),
                                            lv, rv[7:0], cf);
                            res = sh.v;
                            ex_cpsr[29] = sh.c;
                        end
                        TA_ADC: begin ar = add_c(lv, rv, cf); arith = 1'b1; end
                        TA_SBC: begin ar = add_c(lv, ~rv, cf); arith = 1'b1; end
                        TA_TST: begin res = lv & rv; ex_wr = 1'b0; end
                        TA_NEG: begin ar = add_c(32'd0, ~rv, 1'b1); arith = 1'b1; end
                        TA_CMP: begin ar = add_c(lv, ~rv, 1'b1); arith = 1'b1; ex_wr = 1'b0; end
                        TA_CMN: begin ar = add_c(lv, rv, 1'b0); arith = 1'b1; ex_wr = 1'b0; end
                        TA_ORR: res = lv | rv;
                        TA_MUL: res = lv * rv;
                        TA_BIC: res = lv & ~rv;
                        default: res = ~rv;
                    endcase
                    if (arith) begin
                        res = ar.r;
                        ex_cpsr[29] = ar.c;
                        ex_cpsr[28] = ar.o;
                    end
                    ex_cpsr[31] = res[31];
                    ex_cpsr[30] = res == 32'd0;
                    ex_wr_val   = ex_wr ? res : 32'd0;
                    ex_pc       = pc + 32'd2;
                end else if ((ins[15:0] & 16'hE000) == 16'h2000) begin
                    op2b = ins[12:11];
                    rv   = {24'd0, ins[7:0]};
                    if (op2b == IM_MOV) begin
                        res = rv;
                    end else begin
                        ar  = add_c(opa, (op2b == IM_ADD) ? rv : ~rv, op2b != IM_ADD);
                        res = ar.r;
                        ex_cpsr[29] = ar.c;
                        ex_cpsr[28] = ar.o;
                    end
                    ex_cpsr[31] = res[31];
                    ex_cpsr[30] = res == 32'd0;
                    if (op2b != IM_CMP) begin
                        ex_wr     = 1'b1;
                        ex_wr_idx = {1'b0, ins[10:8]};
                        ex_wr_val = res;
                    end
                    ex_pc = pc + 32'd2;
                end else if ((ins[15:0] & 16'hF800) == 16'h1800) begin
                    rv = ins[10] ? {29'd0, ins[8:6]} : opb;
                    ar = add_c(opa, ins[9] ? ~rv : rv, ins[9]);
                    ex_cpsr[31:28] = {ar.r[31], ar.r == 32'd0, ar.c, ar.o};
                    ex_wr     = 1'b1;
                    ex_wr_idx = {1'b0, ins[2:0]};
                    ex_wr_val = ar.r;
                    ex_pc     = pc + 32'd2;
                end else if ((ins[15:0] & 16'hE000) == 16'h0000) begin
                    sh = shift_imm(ins[12:11], opa, ins[10:6], cf);
                    ex_cpsr[31:29] = {sh.v[31], sh.v == 32'd0, sh.c};
                    ex_wr     = 1'b1;
                    ex_wr_idx = {1'b0, ins[2:0]};
                    ex_wr_val = sh.v;
                    ex_pc     = pc + 32'd2;
                end else begin
                    ex_st = ST_UNSUP;
                end
            end

            KIND_IRQ: begin
                if (cpsr_reg[7]) begin
                    ex_st = ST_MASKED;
                end else begin
                    exc_go = 1'b1;
                end
            end

            KIND_FIQ: begin
                if (cpsr_reg[6]) begin
                    ex_st = ST_MASKED;
                end else begin
                    exc_go = 1'b1;
                end
            end

            KIND_RESET: begin
                ex_rst  = 1'b1;
                ex_fl   = 1'b1;
                ex_pc   = 32'd0;
                ex_cpsr = CPSR_RESET;
            end

            default: begin
                exc_go = 1'b1;
            end
        endcase

        // Exception entry: bank the status, switch mode, link and vector
        if (exc_go) begin
            if (exc_swi) begin
                exc_mode = MODE_SVC; exc_vec = VEC_SWI;  exc_ret = pc + step;
            end else begin
                case (s2_data_reg.kind)
                    KIND_IRQ: begin
                        exc_mode = MODE_IRQ; exc_vec = VEC_IRQ;  exc_ret = pc + 32'd4;
                    end
                    KIND_FIQ: begin
                        exc_mode = MODE_FIQ; exc_vec = VEC_FIQ;  exc_ret = pc + 32'd4;
                    end
                    KIND_UND: begin
                        exc_mode = MODE_UND; exc_vec = VEC_UND;  exc_ret = pc + step;
                    end
                    KIND_PABT: begin
                        exc_mode = MODE_ABT; exc_vec = VEC_PABT; exc_ret = pc + 32'd4;
                    end
                    default: begin
                        exc_mode = MODE_ABT; exc_vec = VEC_DABT; exc_ret = pc + 32'd8;
                    end
                endcase
            end
            ex_sv     = 1'b1;
            ex_sv_idx = bank_of(exc_mode) - 3'd1;
            ex_cpsr   = {cpsr_reg[31:8], 1'b1,
                         (!exc_swi && (s2_data_reg.kind == KIND_FIQ)) | cpsr_reg[6],
                         1'b0, exc_mode};
            ex_wr     = 1'b1;
            ex_wr_idx = 4'd14;
            ex_wr_val = exc_ret;
            wr_mode   = exc_mode;
            ex_pc     = exc_vec;
            ex_fl     = 1'b1;
        end

        ex_wr_phys = phys_of(ex_wr_idx, wr_mode);
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= 32'd0;
            cpsr_reg     <= CPSR_RESET;
            for (int i = 0; i < SV_DEPTH; i++) begin
                saved_reg[i] <= 32'd0;
            end
            rf_valid_reg <= '0;
            fw_en_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_ph_reg    <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Commit the executing item
            if (commit) begin
                pc_reg   <= ex_pc;
                cpsr_reg <= ex_cpsr;
                if (ex_rst) begin
                    for (int i = 0; i < SV_DEPTH; i++) begin
                        saved_reg[i] <= 32'd0;
                    end
                    rf_valid_reg <= '0;
                end else begin
                    if (ex_sv) begin
                        saved_reg[ex_sv_idx] <= cpsr_reg;
                    end
                    if (ex_wr) begin
                        rf_valid_reg[ex_wr_phys] <= 1'b1;
                    end
                end
            end
            fw_en_reg <= commit && ex_wr && !ex_rst;

            // Read stage: take a new item, or hold and step the read phase
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
                s1_ph_reg    <= 1'b0;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end else if (s1_ph_go) begin
                s1_ph_reg <= 1'b1;
            end

            // Execute stage occupancy
            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
            end else if (commit) begin
                s2_valid_reg <= 1'b0;
            end

            // Result register
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and register file memory
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (commit && ex_wr && !ex_rst) begin
            rf_mem[ex_wr_phys] <= ex_wr_val;
        end
        if (s2_valid_reg && !commit) begin
            // Hold the resolved operands of a stalled execute item
            ra_data_reg <= opa;
            rb_data_reg <= opb;
            va_reg      <= 1'b1;
            vb_reg      <= 1'b1;
        end else begin
            ra_data_reg <= rf_mem[rd_a];
            rb_data_reg <= rf_mem[rd_b];
            ra_addr_reg <= rd_a;
            rb_addr_reg <= rd_b;
            va_reg      <= rf_valid_reg[rd_a];
            vb_reg      <= rf_valid_reg[rd_b];
        end
        fw_addr_reg <= ex_wr_phys;
        fw_data_reg <= ex_wr_val;

        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
        if (s1_adv) begin
            s2_data_reg <= s1_data_reg;
            // Port A carries the shift register value in the second read phase
            s2_rs_reg   <= opa;
        end
        if (commit) begin
            m_data_reg.result_status <= ex_st;
            m_data_reg.flushed       <= ex_fl;
            m_data_reg.next_pc       <= ex_pc;
            m_data_reg.status_word   <= ex_cpsr;
            m_data_reg.reg_written   <= ex_wr;
            m_data_reg.reg_index     <= ex_wr ? ex_wr_idx : 4'd0;
            m_data_reg.reg_value     <= ex_wr ? ex_wr_val : 32'd0;
        end
    end

endmodule

FILE: src/bce_checker.sv
// Port-level checker of the banked execution core and its bind.
`include "banked_core_alu_branch_exec_core_defines.svh"

module bce_checker
    import bce_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input bce_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input bce_out_t m_data
);

    `BCE_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result item changed while stalled")
    `BCE_ASSERT_ALWAYS(a_quiet_status, aclk, aresetn, m_valid && (m_data.result_status != ST_EXEC) |-> !m_data.flushed && !m_data.reg_written, "non-executed item flushed or wrote")
    `BCE_ASSERT_ALWAYS(a_no_pc_write, aclk, aresetn, m_valid && m_data.reg_written |-> m_data.reg_index != 4'd15, "register write reported for the PC")
    `BCE_ASSERT_ALWAYS(a_idle_write_zero, aclk, aresetn, m_valid && !m_data.reg_written |-> (m_data.reg_index == 4'd0) && (m_data.reg_value == 32'd0), "write fields not cleared")

endmodule

bind banked_core_alu_branch_exec_core bce_checker u_bce_checker (.*);
